// ===== hdl/cfpr_pkg.sv =====
// Shared types, constants and the CRC byte update for the flash packet receiver.
// No dependencies; the receiver top level uses this package by scoped names.
package cfpr_pkg;

	typedef logic [2:0] kind_t;

	localparam kind_t KIND_LEN_ACK    = 3'd0;
	localparam kind_t KIND_ERASE      = 3'd1;
	localparam kind_t KIND_DATA       = 3'd2;
	localparam kind_t KIND_OK         = 3'd3;
	localparam kind_t KIND_CRC_ERR    = 3'd4;
	localparam kind_t KIND_RANGE_ERR  = 3'd5;
	localparam kind_t KIND_FORMAT_ERR = 3'd6;
	localparam kind_t KIND_END        = 3'd7;

	localparam logic CFG_FLASH_END   = 1'b0;
	localparam logic CFG_ERASE_PAGES = 1'b1;

	localparam logic [31:0] FLASH_END_RST   = 32'h0003_FFFF;
	localparam logic [7:0]  ERASE_PAGES_RST = 8'd1;

	localparam logic [31:0] CRC_POLY = 32'h04C1_1DB7;
	localparam logic [31:0] CRC_SEED = 32'hFFFF_FFFF;

	// One byte of the CRC: the byte goes into the low bits, then 32 shifts.
	// Unrolled, this is a fixed XOR network of the 32 incoming bits.
	function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] c;
		c = crc ^ {24'd0, b};
		for (int k = 0; k < 32; k++) begin
			c = c[31] ? ({c[30:0], 1'b0} ^ CRC_POLY) : {c[30:0], 1'b0};
		end
		return c;
	endfunction

endpackage

// ===== hdl/crc_checked_flash_packet_receiver.sv =====
// Top level of the CRC-checked flash packet receiver: byte parser, CRC and verdicts.
// Depends on cfpr_pkg for result codes, register indexes and the CRC byte update.
//
//   channel   direction  handshake              payload
//   input     in         in_valid / in_stall    rx_byte
//   result    out        out_valid / out_stall  kind, address, data_value, count,
//                                               entry_known, crc_value
//   config    in         cfg_write              cfg_index, cfg_data
//
// Each byte is held in the input register and then passes through the parser,
// the unrolled CRC network and the range adder into the result register, so the
// block sustains one beat per cycle while out_stall is low. A stalled result holds
// the result register; the input register then holds its byte, and in_stall rises
// only when both registers are full. Reset is asynchronous and clears all control
// state, restores the configuration defaults and starts a new session.
module crc_checked_flash_packet_receiver (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  kind,
	output logic [31:0] address,
	output logic [7:0]  data_value,
	output logic [7:0]  count,
	output logic        entry_known,
	output logic [31:0] crc_value,
	input  logic        cfg_write,
	input  logic        cfg_index,
	input  logic [31:0] cfg_data
);

	// Configuration registers.
	logic [31:0] flash_end_q;
	logic [7:0]  erase_pages_q;

	// Input register stage.
	logic        valid_s1;
	logic [7:0]  byte_s1;

	// Result register stage.
	logic              valid_s2;
	cfpr_pkg::kind_t   kind_s2;
	logic [31:0]       address_s2;
	logic [7:0]        data_s2;
	logic [7:0]        count_s2;
	logic              entry_known_s2;
	logic [31:0]       crc_s2;

	// Packet and session state.
	logic        in_packet_q;
	logic [7:0]  pos_q;
	logic [7:0]  len_q;
	logic [31:0] tgt_q;
	logic [7:0]  dc_q;
	logic [31:0] run_crc_q;
	logic [31:0] rcv_crc_q;
	logic        first_q;
	logic [31:0] entry_q;
	logic        entry_cap_q;

	// Next-state values and the candidate result.
	logic        n_in_packet;
	logic [7:0]  n_pos;
	logic [7:0]  n_len;
	logic [31:0] n_tgt;
	logic [7:0]  n_dc;
	logic [31:0] n_run_crc;
	logic [31:0] n_rcv_crc;
	logic        n_first;
	logic [31:0] n_entry;
	logic        n_entry_cap;

	logic              emit;
	cfpr_pkg::kind_t   r_kind;
	logic [31:0]       r_address;
	logic [7:0]        r_data;
	logic [7:0]        r_count;
	logic              r_entry_known;
	logic [31:0]       r_crc;

	// Position arithmetic, kept at nine bits so nothing wraps.
	logic [8:0]  pos9;
	logic [8:0]  len9;
	logic [8:0]  rcv_k;
	logic        crc_cover;
	logic [32:0] range_sum;
	logic [7:0]  data_off;

	// Handshake control.
	logic advance;
	logic fire;
	logic load_s1;

	// The result register frees when it is empty or its beat leaves this cycle.
	assign advance  = !valid_s2 || !out_stall;
	assign fire     = valid_s1 && advance;
	assign load_s1  = !valid_s1 || advance;
	assign in_stall = !load_s1;

	assign out_valid   = valid_s2;
	assign kind        = kind_s2;
	assign address     = address_s2;
	assign data_value  = data_s2;
	assign count       = count_s2;
	assign entry_known = entry_known_s2;
	assign crc_value   = crc_s2;

	assign pos9      = {1'b0, pos_q + 8'd1};
	assign len9      = {1'b0, len_q};
	assign crc_cover = (pos9 + 9'd4) <= len9;
	assign rcv_k     = pos9 + 9'd3 - len9;
	assign data_off  = pos9[7:0] - 8'd7;

	always_comb begin
		n_in_packet   = in_packet_q;
		n_pos         = pos_q;
		n_len         = len_q;
		n_tgt         = tgt_q;
		n_dc          = dc_q;
		n_run_crc     = run_crc_q;
		n_rcv_crc     = rcv_crc_q;
		n_first       = first_q;
		n_entry       = entry_q;
		n_entry_cap   = entry_cap_q;
		emit          = 1'b0;
		r_kind        = cfpr_pkg::KIND_LEN_ACK;
		r_address     = 32'd0;
		r_data        = 8'd0;
		r_count       = 8'd0;
		r_entry_known = 1'b0;
		r_crc         = 32'd0;
		range_sum     = 33'd0;

		if (!in_packet_q) begin
			emit = 1'b1;
			if (byte_s1 == 8'd0) begin
				// End of image: report the entry point and open a new session.
				r_kind        = cfpr_pkg::KIND_END;
				r_address     = entry_cap_q ? entry_q : 32'd0;
				r_entry_known = entry_cap_q;
				n_first       = 1'b1;
				n_entry_cap   = 1'b0;
				n_entry       = 32'd0;
			end else begin
				// Length byte opens a packet; it is covered by the CRC when L >= 4.
				n_len       = byte_s1;
				n_pos       = 8'd0;
				n_tgt       = 32'd0;
				n_dc        = 8'd0;
				n_rcv_crc   = 32'd0;
				n_run_crc   = (byte_s1 >= 8'd4) ?
					cfpr_pkg::crc_byte(cfpr_pkg::CRC_SEED, byte_s1) : cfpr_pkg::CRC_SEED;
				n_in_packet = 1'b1;
				r_kind      = cfpr_pkg::KIND_LEN_ACK;
			end
		end else begin
			n_pos = pos9[7:0];
			if (crc_cover) begin
				n_run_crc = cfpr_pkg::crc_byte(run_crc_q, byte_s1);
			end
			// The last four bytes build the received CRC, low byte first.
			if ((pos9 + 9'd3) >= len9 && rcv_k[8:2] == 7'd0) begin
				n_rcv_crc[{rcv_k[1:0], 3'b000} +: 8] =
					n_rcv_crc[{rcv_k[1:0], 3'b000} +: 8] | byte_s1;
			end
			if (pos9 >= 9'd2 && pos9 <= 9'd5) begin
				n_tgt[{pos9[1:0] - 2'd2, 3'b000} +: 8] =
					n_tgt[{pos9[1:0] - 2'd2, 3'b000} +: 8] | byte_s1;
			end
			if (pos9 == 9'd6) begin
				n_dc = byte_s1;
			end
			// The first packet of a session carries the entry address in bytes 11 to 14.
			if (first_q && pos9 >= 9'd11 && pos9 <= 9'd14) begin
				if (pos9 == 9'd11) begin
					n_entry = {24'd0, byte_s1};
				end else begin
					n_entry[{pos9[1:0] - 2'd3, 3'b000} +: 8] =
						n_entry[{pos9[1:0] - 2'd3, 3'b000} +: 8] | byte_s1;
				end
				if (pos9 == 9'd14) begin
					n_entry_cap = 1'b1;
				end
			end

			range_sum = {1'b0, n_tgt} + {25'd0, len_q};

			if (pos9 >= len9) begin
				// Last byte: the verdict takes precedence over any other result.
				emit        = 1'b1;
				n_in_packet = 1'b0;
				if (len_q < 8'd10) begin
					r_kind = cfpr_pkg::KIND_FORMAT_ERR;
				end else if (n_rcv_crc != n_run_crc) begin
					r_kind = cfpr_pkg::KIND_CRC_ERR;
				end else if (range_sum > {1'b0, flash_end_q}) begin
					r_kind = cfpr_pkg::KIND_RANGE_ERR;
				end else begin
					r_kind = cfpr_pkg::KIND_OK;
				end
				if (len_q >= 8'd7) begin
					n_first = 1'b0;
				end
				r_address = n_tgt;
				r_count   = n_dc;
				r_crc     = n_run_crc;
			end else if (pos9 == 9'd6 && first_q) begin
				emit      = 1'b1;
				r_kind    = cfpr_pkg::KIND_ERASE;
				r_address = n_tgt;
				r_count   = erase_pages_q;
			end else if (pos9 >= 9'd7 && pos9 < (9'd7 + {1'b0, dc_q}) && crc_cover) begin
				emit      = 1'b1;
				r_kind    = cfpr_pkg::KIND_DATA;
				r_address = tgt_q + {24'd0, data_off};
				r_data    = byte_s1;
			end
		end
	end

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flash_end_q   <= cfpr_pkg::FLASH_END_RST;
			erase_pages_q <= cfpr_pkg::ERASE_PAGES_RST;
		end else if (cfg_write) begin
			case (cfg_index)
				cfpr_pkg::CFG_FLASH_END:   flash_end_q   <= cfg_data;
				cfpr_pkg::CFG_ERASE_PAGES: erase_pages_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load_s1) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1 && in_valid) begin
			byte_s1 <= rx_byte;
		end
	end

	// Packet and session state advance once per processed byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_packet_q <= 1'b0;
			pos_q       <= 8'd0;
			len_q       <= 8'd0;
			tgt_q       <= 32'd0;
			dc_q        <= 8'd0;
			run_crc_q   <= cfpr_pkg::CRC_SEED;
			rcv_crc_q   <= 32'd0;
			first_q     <= 1'b1;
			entry_q     <= 32'd0;
			entry_cap_q <= 1'b0;
		end else if (fire) begin
			in_packet_q <= n_in_packet;
			pos_q       <= n_pos;
			len_q       <= n_len;
			tgt_q       <= n_tgt;
			dc_q        <= n_dc;
			run_crc_q   <= n_run_crc;
			rcv_crc_q   <= n_rcv_crc;
			first_q     <= n_first;
			entry_q     <= n_entry;
			entry_cap_q <= n_entry_cap;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= fire && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && emit) begin
			kind_s2        <= r_kind;
			address_s2     <= r_address;
			data_s2        <= r_data;
			count_s2       <= r_count;
			entry_known_s2 <= r_entry_known;
			crc_s2         <= r_crc;
		end
	end

endmodule

// ===== verif/cfpr_tb_pkg.sv =====
// CRC-32 byte update used by the flash packet receiver testbench to build and predict packets.
// Depends on cfpr_pkg for the polynomial; shared by the response checker and the stimulus top.
`timescale 1ns / 100ps

package cfpr_tb_pkg;

	// Fold one byte into the running CRC: byte into the low bits, then 32 left shifts.
	function automatic logic [31:0] crc_next(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] r;
		logic msb;
		r = crc ^ {24'h0, b};
		repeat (32) begin
			msb = r[31];
			r = r << 1;
			if (msb)
				r = r ^ cfpr_pkg::CRC_POLY;
		end
		return r;
	endfunction

endpackage

// ===== verif/cfpr_response_checker.sv =====
// Response checker for the flash packet receiver: watches the byte, result and register ports.
// Depends on cfpr_pkg (result codes, register indexes, defaults) and cfpr_tb_pkg (CRC update).
`timescale 1ns / 100ps

module cfpr_response_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [7:0]  rx_byte,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [2:0]  kind,
	input  logic [31:0] address,
	input  logic [7:0]  data_value,
	input  logic [7:0]  count,
	input  logic        entry_known,
	input  logic [31:0] crc_value,
	input  logic        cfg_write,
	input  logic        cfg_index,
	input  logic [31:0] cfg_data,
	output int          mismatches,
	output int          open_responses,
	output int          responses_checked,
	output int          verdicts_checked
);

	import cfpr_pkg::*;
	import cfpr_tb_pkg::*;

	typedef struct packed {
		kind_t       kind;
		logic [31:0] address;
		logic [7:0]  data_value;
		logic [7:0]  count;
		logic        entry_known;
		logic [31:0] crc_value;
	} response_t;

	response_t pending_responses[$];
	response_t want;
	response_t fresh;

	// Register copies and parser state of the receiver.
	logic [31:0] flash_end_q;
	logic [7:0]  erase_pages_q;
	logic        in_pkt;
	logic [7:0]  pos;
	logic [7:0]  pkt_len;
	logic [31:0] tgt;
	logic [7:0]  dcount;
	logic [31:0] crc_run;
	logic [31:0] crc_rx;
	logic        first_pkt;
	logic [31:0] entry_addr;
	logic        entry_got;

	task automatic report(input string field, input logic [31:0] got, input logic [31:0] exp_val);
		mismatches++;
		if (mismatches <= 40)
			$display("%0t ns: %s got %h, expected %h (expected kind %0d)",
				$time, field, got, exp_val, want.kind);
	endtask

	// Advances the parser by one byte; returns 1 when the byte produces a response.
	function automatic bit expected_response(input logic [7:0] b, output response_t r);
		int unsigned p;
		int unsigned len;
		r = '0;
		if (!in_pkt) begin
			if (b == 8'h00) begin
				r.kind = KIND_END;
				r.address = entry_got ? entry_addr : 32'h0;
				r.entry_known = entry_got;
				first_pkt = 1'b1;
				entry_got = 1'b0;
				entry_addr = 32'h0;
			end else begin
				pkt_len = b;
				pos = 8'h00;
				tgt = 32'h0;
				dcount = 8'h00;
				crc_rx = 32'h0;
				crc_run = (b >= 8'd4) ? crc_next(CRC_SEED, b) : CRC_SEED;
				in_pkt = 1'b1;
				r.kind = KIND_LEN_ACK;
			end
			return 1'b1;
		end

		len = pkt_len;
		p = (pos + 1) & 8'hFF;
		pos = p[7:0];

		if (p + 4 <= len)
			crc_run = crc_next(crc_run, b);
		if (p + 3 >= len && p + 3 - len < 4)
			crc_rx = crc_rx | ({24'h0, b} << (8 * (p + 3 - len)));
		if (p >= 2 && p <= 5)
			tgt = tgt | ({24'h0, b} << (8 * (p - 2)));
		if (p == 6)
			dcount = b;
		if (first_pkt && p >= 11 && p <= 14) begin
			if (p == 11)
				entry_addr = {24'h0, b};
			else
				entry_addr = entry_addr | ({24'h0, b} << (8 * (p - 11)));
			if (p == 14)
				entry_got = 1'b1;
		end

		if (p >= len) begin
			in_pkt = 1'b0;
			if (len < 10)
				r.kind = KIND_FORMAT_ERR;
			else if (crc_rx != crc_run)
				r.kind = KIND_CRC_ERR;
			else if ({32'h0, tgt} + {32'h0, len} > {32'h0, flash_end_q})
				r.kind = KIND_RANGE_ERR;
			else
				r.kind = KIND_OK;
			if (len >= 7)
				first_pkt = 1'b0;
			r.address = tgt;
			r.count = dcount;
			r.crc_value = crc_run;
			return 1'b1;
		end

		if (p == 6 && first_pkt) begin
			r.kind = KIND_ERASE;
			r.address = tgt;
			r.count = erase_pages_q;
			return 1'b1;
		end

		if (p >= 7 && p < 7 + dcount && p + 4 <= len) begin
			r.kind = KIND_DATA;
			r.address = tgt + (p - 7);
			r.data_value = b;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flash_end_q = FLASH_END_RST;
			erase_pages_q = ERASE_PAGES_RST;
			in_pkt = 1'b0;
			pos = 8'h00;
			pkt_len = 8'h00;
			tgt = 32'h0;
			dcount = 8'h00;
			crc_run = CRC_SEED;
			crc_rx = 32'h0;
			first_pkt = 1'b1;
			entry_addr = 32'h0;
			entry_got = 1'b0;
			pending_responses.delete();
			open_responses <= 0;
		end else begin
			// Results are compared before this edge's input is predicted, since an
			// input beat can never come back out on the edge that accepts it.
			if (out_valid && !out_stall) begin
				if (pending_responses.size() == 0) begin
					want = '0;
					report("result beat with nothing expected, kind", {29'h0, kind}, 32'h0);
				end else begin
					want = pending_responses.pop_front();
					if (kind !== want.kind)
						report("kind", {29'h0, kind}, {29'h0, want.kind});
					if (address !== want.address)
						report("address", address, want.address);
					if (data_value !== want.data_value)
						report("data_value", {24'h0, data_value}, {24'h0, want.data_value});
					if (count !== want.count)
						report("count", {24'h0, count}, {24'h0, want.count});
					if (entry_known !== want.entry_known)
						report("entry_known", {31'h0, entry_known}, {31'h0, want.entry_known});
					if (crc_value !== want.crc_value)
						report("crc_value", crc_value, want.crc_value);
					responses_checked++;
					if (want.kind >= KIND_OK && want.kind <= KIND_FORMAT_ERR)
						verdicts_checked++;
				end
			end
			if (cfg_write) begin
				if (cfg_index == CFG_FLASH_END)
					flash_end_q = cfg_data;
				else
					erase_pages_q = cfg_data[7:0];
			end
			if (in_valid && !in_stall) begin
				if (expected_response(rx_byte, fresh))
					pending_responses.push_back(fresh);
			end
			open_responses <= pending_responses.size();
		end
	end

endmodule

// ===== verif/tb_crc_checked_flash_packet_receiver.sv =====
// Testbench top for the CRC-checked flash packet receiver: clock, reset, byte stimulus and verdict.
// Depends on cfpr_pkg, cfpr_tb_pkg, the response checker and the receiver RTL.
`timescale 1ns / 100ps

module tb_crc_checked_flash_packet_receiver;

	import cfpr_pkg::*;
	import cfpr_tb_pkg::*;

	// Packet shapes the generator can produce.
	localparam int SHAPE_CLEAN   = 0;
	localparam int SHAPE_BAD_CRC = 1;
	localparam int SHAPE_NOISE   = 2;

	// Length of the one long output hold that backs the block up.
	localparam int HOLD_CYCLES = 80;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [7:0]  rx_byte;
	logic        out_valid;
	logic        out_stall;
	logic [2:0]  kind;
	logic [31:0] address;
	logic [7:0]  data_value;
	logic [7:0]  count;
	logic        entry_known;
	logic [31:0] crc_value;
	logic        cfg_write;
	logic        cfg_index;
	logic [31:0] cfg_data;

	int mismatches;
	int open_responses;
	int responses_checked;
	int verdicts_checked;

	// Stimulus bookkeeping.
	bit          idle_on;
	bit          hold_req;
	logic [31:0] flash_end_now;
	int          bytes_sent;
	int          ends_sent;
	int          settings_done;

	crc_checked_flash_packet_receiver uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.rx_byte     (rx_byte),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.kind        (kind),
		.address     (address),
		.data_value  (data_value),
		.count       (count),
		.entry_known (entry_known),
		.crc_value   (crc_value),
		.cfg_write   (cfg_write),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	cfpr_response_checker resp_checker (
		.clk               (clk),
		.arst_n            (arst_n),
		.in_valid          (in_valid),
		.in_stall          (in_stall),
		.rx_byte           (rx_byte),
		.out_valid         (out_valid),
		.out_stall         (out_stall),
		.kind              (kind),
		.address           (address),
		.data_value        (data_value),
		.count             (count),
		.entry_known       (entry_known),
		.crc_value         (crc_value),
		.cfg_write         (cfg_write),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data),
		.mismatches        (mismatches),
		.open_responses    (open_responses),
		.responses_checked (responses_checked),
		.verdicts_checked  (verdicts_checked)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hard stop in case the block deadlocks or drops a result.
	initial begin
		#5_000_000;
		$display("Regression FAIL");
		$finish;
	end

	// Result side. Every change happens on a falling edge. Short random stall bursts
	// come while idling is on; a hold request from the stimulus turns into one long
	// stall that is counted here, so the sender keeps pushing and the block backs up.
	initial begin : result_sink
		int stall_left;
		stall_left = 0;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				stall_left = HOLD_CYCLES;
				hold_req = 1'b0;
			end else if (stall_left == 0 && idle_on && $urandom_range(0, 6) == 0) begin
				stall_left = $urandom_range(1, 14);
			end
			if (stall_left > 0) begin
				out_stall = 1'b1;
				stall_left--;
			end else begin
				out_stall = 1'b0;
			end
		end
	end

	// Offers one byte beat, starting and ending on a falling edge. A random idle gap
	// may come first. Valid stays high between back-to-back beats, and the byte is
	// held until the block takes it.
	task automatic send_byte(input logic [7:0] b);
		if (idle_on && $urandom_range(0, 5) == 0) begin
			in_valid = 1'b0;
			repeat ($urandom_range(1, 14)) @(negedge clk);
		end
		in_valid = 1'b1;
		rx_byte = b;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		bytes_sent++;
		@(negedge clk);
	endtask

	// Builds and sends one packet: the length byte, the address and data count, random
	// data, and the CRC over bytes 0..len-4 in the last four positions. A bad-CRC
	// packet has one bit of its CRC flipped; a noise packet is random after the length.
	task automatic send_packet(input int len, input logic [31:0] addr, input logic [7:0] dcnt,
			input int shape);
		logic [7:0]  pkt [0:255];
		logic [31:0] crc;
		int          p;
		int          idx;
		pkt[0] = len[7:0];
		for (p = 1; p <= len; p++)
			pkt[p] = 8'($urandom_range(0, 255));
		if (shape != SHAPE_NOISE) begin
			for (p = 2; p <= 5 && p <= len; p++)
				pkt[p] = addr[8 * (p - 2) +: 8];
			if (len >= 6)
				pkt[6] = dcnt;
			crc = CRC_SEED;
			for (p = 0; p + 4 <= len; p++)
				crc = crc_next(crc, pkt[p]);
			// The CRC tail overwrites whatever role those positions also carry.
			for (p = 1; p <= len; p++) begin
				if (p + 3 >= len)
					pkt[p] = crc[8 * (p + 3 - len) +: 8];
			end
			if (shape == SHAPE_BAD_CRC) begin
				idx = len - 3 + $urandom_range(0, 3);
				if (idx < 1)
					idx = 1;
				pkt[idx] = pkt[idx] ^ (8'h01 << $urandom_range(0, 7));
			end
		end
		for (p = 0; p <= len; p++)
			send_byte(pkt[p]);
	endtask

	// Registers only change with the block drained. A byte may produce no result, so
	// the wait runs on past the last expected result so such bytes clear both stages.
	task automatic reconfigure(input logic [31:0] fe, input logic [7:0] pages);
		in_valid = 1'b0;
		while (open_responses != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
		cfg_write = 1'b1;
		cfg_index = CFG_FLASH_END;
		cfg_data = fe;
		flash_end_now = fe;
		@(negedge clk);
		cfg_index = CFG_ERASE_PAGES;
		cfg_data = {24'h0, pages};
		@(negedge clk);
		cfg_write = 1'b0;
		settings_done++;
	endtask

	// Random traffic of whole packets until at least nbytes beats have gone in. Most
	// packets are well formed and in range, so sessions get past the length and
	// header bytes; the rest are bad CRCs, range violations, short noise and
	// end-of-image markers that restart the session.
	task automatic run_phase(input int nbytes);
		int          start;
		int          roll;
		int          len;
		int          shape;
		int          room;
		logic [31:0] lim;
		logic [31:0] addr;
		logic [7:0]  dcnt;
		start = bytes_sent;
		while (bytes_sent - start < nbytes) begin
			roll = $urandom_range(0, 99);
			if (roll < 6) begin
				send_byte(8'h00);
				ends_sent++;
			end else begin
				// Mostly short packets; now and then a long one up to the maximum length.
				len = ($urandom_range(0, 19) == 0) ? $urandom_range(41, 255) : $urandom_range(10, 40);
				shape = SHAPE_CLEAN;
				if (roll < 14) begin
					shape = SHAPE_NOISE;
					len = $urandom_range(1, 12);
				end else if (roll < 20) begin
					shape = SHAPE_BAD_CRC;
				end
				if (roll >= 20 && roll < 27) begin
					// Past the end of flash, often by exactly one byte.
					lim = (flash_end_now >= len) ? flash_end_now - len + 1 : 32'h0;
					addr = $urandom_range(0, 1) ? lim : $urandom_range(lim, 32'hFFFF_FFFF);
				end else if (flash_end_now >= len) begin
					// In range, sometimes ending right on the last flash address.
					lim = flash_end_now - len;
					addr = ($urandom_range(0, 3) == 0) ? lim : $urandom_range(0, lim);
				end else begin
					addr = $urandom;
				end
				room = (len >= 10) ? len - 10 : 0;
				dcnt = 8'(($urandom_range(0, 4) == 0) ? $urandom_range(0, 255) :
					$urandom_range(0, room));
				send_packet(len, addr, dcnt, shape);
			end
		end
		in_valid = 1'b0;
	endtask

	initial begin : stimulus
		int waited;
		arst_n = 1'b0;
		in_valid = 1'b0;
		rx_byte = 8'h00;
		cfg_write = 1'b0;
		cfg_index = CFG_FLASH_END;
		cfg_data = 32'h0;
		idle_on = 1'b1;
		hold_req = 1'b0;
		flash_end_now = FLASH_END_RST;
		bytes_sent = 0;
		ends_sent = 0;
		settings_done = 0;

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed opening with the reset register values. An end-of-image marker
		// before any entry address, then a three-byte packet of all-ones (too short,
		// CRC stays at the seed, first-packet flag survives), then a minimal packet
		// that carries the entry address: erase at byte 6, data count 255 clipped
		// by the CRC tail, entry bytes 11..14 shared with the CRC. The final marker
		// must report the captured entry.
		send_byte(8'h00);
		ends_sent++;
		send_byte(8'd3);
		repeat (3) send_byte(8'hFF);
		send_packet(14, 32'h0000_0000, 8'hFF, SHAPE_CLEAN);
		send_byte(8'h00);
		ends_sent++;
		in_valid = 1'b0;

		// Widest flash and the largest erase count.
		reconfigure(32'hFFFF_FFFF, 8'd255);
		run_phase(150);

		// Empty flash: every well-formed packet runs out of range.
		reconfigure(32'h0000_0000, 8'd1);
		run_phase(90);

		// Random settings with one long output hold while bytes keep coming.
		reconfigure($urandom_range(32'h0000_0100, 32'h000F_FFFF), 8'($urandom_range(1, 254)));
		hold_req = 1'b1;
		run_phase(170);

		reconfigure(FLASH_END_RST, ERASE_PAGES_RST);
		run_phase(120);

		// Closing stretch at full rate on both sides.
		reconfigure($urandom, 8'($urandom_range(1, 255)));
		idle_on = 1'b0;
		run_phase(150);

		in_valid = 1'b0;
		waited = 0;
		while (open_responses != 0 && waited < 20000) begin
			@(negedge clk);
			waited++;
		end
		repeat (10) @(negedge clk);

		if (open_responses != 0)
			$display("%0d expected result beats never arrived", open_responses);
		$display("Drove %0d byte beats (%0d end-of-image markers) under %0d register settings,",
			bytes_sent, ends_sent, settings_done + 1);
		$display("with idle gaps, stall bursts and one long hold; checked %0d result beats, %0d verdicts.",
			responses_checked, verdicts_checked);
		if (mismatches == 0 && open_responses == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
